// ===== sv/alt_pkg.sv =====
// ----------------------------------------------------------------------------
// alt_pkg
// Shared types and defaults for the array list table engine.
// ----------------------------------------------------------------------------
package alt_pkg;

   localparam int unsigned DEPTH_DEF         = 32;
   localparam int unsigned ELEMENT_WIDTH_DEF = 32;

   typedef enum logic [2:0] {
      CMD_APPEND = 3'd0,
      CMD_INSERT = 3'd1,
      CMD_DELETE = 3'd2,
      CMD_FIND   = 3'd3,
      CMD_GET    = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [2:0] {
      ST_OK       = 3'd0,
      ST_FULL     = 3'd1,
      ST_BADPOS   = 3'd2,
      ST_EMPTY    = 3'd3,
      ST_NOTFOUND = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_FINISH
   } state_type;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic ins;
      logic del;
      logic app;
      logic scan_clr;
      logic scan_step;
      logic find_mode;
   } op_type;

   typedef struct packed {
      status_type  status;
      logic [31:0] read_value;
      logic [4:0]  found_index;
      logic [5:0]  count;
      logic        is_empty;
   } res_type;

endpackage

// ===== sv/array_list_table_engine.sv =====
// ----------------------------------------------------------------------------
// array_list_table_engine
// Bounded ordered list of signed elements kept in a row of shift cells.
// ----------------------------------------------------------------------------
// Each request transaction carries one command and gives exactly one response
// transaction. Append, insert, delete, clear, unused commands and a failing
// get respond from the idle state without a scan: the cells at and above the
// position shift up or down together. Find and a valid get walk a scan carry
// from the top cell to cell zero, one cell per cycle, passing through the
// accepting idle state, the scan steps and a finishing state that posts the
// result; the lowest matching cell wins because it overrides whatever arrives
// from above. The block takes one command at a time. A response register plus
// one holding slot let a new command enter while an earlier response is still
// stalled. The miss value register (csr_write_data) is what a get outside the
// filled entries returns; write it only while the block is idle.
// ----------------------------------------------------------------------------
module array_list_table_engine
   import alt_pkg::*;
#(
   parameter int unsigned DEPTH         = DEPTH_DEF,
   parameter int unsigned ELEMENT_WIDTH = ELEMENT_WIDTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [2:0]  req_command,
   input  logic [5:0]  req_position,
   input  logic signed [31:0] req_value,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic signed [31:0] rsp_read_value,
   output logic [4:0]  rsp_found_index,
   output logic [5:0]  rsp_count,
   output logic        rsp_is_empty,
   // miss value register
   input  logic        csr_write_enable,
   input  logic signed [31:0] csr_write_data
);

   localparam int unsigned EW    = ELEMENT_WIDTH;
   localparam int unsigned IW    = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam int unsigned CW    = (CNT_W > 6) ? CNT_W : 6;   // compare width
   localparam int unsigned FW    = (IW > 5) ? IW : 5;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
   localparam logic [IW-1:0]    LAST_STEP = IW'(DEPTH - 1);

   // control state
   state_type        state_ff, state_in;
   logic [IW-1:0]    scan_cnt_ff, scan_cnt_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      err_ff, err_in;
   cmd_type          cmd_ff, cmd_in;
   logic [EW-1:0]    key_ff, key_in;
   logic [CW-1:0]    pos_ff, pos_in;

   // response staging
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_ff, rsp_in;
   logic    pend_valid_ff, pend_valid_in;
   res_type pend_ff, pend_in;

   logic          accept;
   cmd_type       cmd_c;
   logic [EW-1:0] key_c;
   logic [CW-1:0] pos_c;
   logic [CW-1:0] cnt_x;
   logic          full_c;
   logic          go_scan;
   op_type        op;
   logic          res_valid;
   res_type       res;
   logic [CW-1:0] cell_pos;
   logic [EW-1:0] cell_key;
   logic [CW-1:0] cnt_after_x;
   logic [31:0]   scan_rd;
   logic [FW-1:0] scan_idx_x;

   // cell row; slot DEPTH is the empty carry entering the top cell
   logic [EW-1:0] entry_w [DEPTH];
   logic          hit_w   [DEPTH+1];
   logic [EW-1:0] val_w   [DEPTH+1];
   logic [IW-1:0] idx_w   [DEPTH+1];

   assign cmd_c  = cmd_type'(req_command);
   assign pos_c  = CW'(req_position);
   assign cnt_x  = CW'(count_ff);
   assign full_c = (count_ff == FULL_CNT);

   // element width adaptation of the 32-bit fields
   generate
      if (EW <= 32) begin : g_key_narrow
         assign key_c = req_value[EW-1:0];
      end else begin : g_key_wide
         assign key_c = {{(EW-32){req_value[31]}}, req_value};
      end
      if (EW >= 32) begin : g_rd_wide
         assign scan_rd = val_w[0][31:0];
      end else begin : g_rd_narrow
         assign scan_rd = {{(32-EW){val_w[0][EW-1]}}, val_w[0]};
      end
   endgenerate

   assign req_stall = (state_ff != S_IDLE) || pend_valid_ff;
   assign accept    = req_valid && !req_stall;
   assign go_scan   = accept &&
                      ((cmd_c == CMD_FIND) || (cmd_c == CMD_GET && pos_c < cnt_x));

   // commands latched for the scan; live inputs drive the cells in IDLE
   assign cell_key = (state_ff == S_IDLE) ? key_c : key_ff;
   assign cell_pos = (state_ff == S_IDLE) ? pos_c : pos_ff;

   assign scan_idx_x  = FW'(idx_w[0]);
   assign cnt_after_x = CW'(count_in);

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (go_scan) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (scan_cnt_ff == LAST_STEP) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // command decode, cell ops and result fields
   always_comb begin
      op              = '0;
      op.find_mode    = (state_ff == S_IDLE) ? 1'b0 : (cmd_ff == CMD_FIND);
      count_in        = count_ff;
      res_valid       = 1'b0;
      res.status      = ST_OK;
      res.read_value  = '0;
      res.found_index = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               res_valid = 1'b1;
               unique case (cmd_c)
                  CMD_APPEND: begin
                     if (full_c) begin
                        res.status = ST_FULL;
                     end else begin
                        op.app   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_INSERT: begin
                     if (full_c) begin
                        res.status = ST_FULL;
                     end else if (pos_c > cnt_x) begin
                        res.status = ST_BADPOS;
                     end else begin
                        op.ins   = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  CMD_DELETE: begin
                     if (count_ff == '0) begin
                        res.status = ST_EMPTY;
                     end else if (pos_c >= cnt_x) begin
                        res.status = ST_BADPOS;
                     end else begin
                        op.del   = 1'b1;
                        count_in = count_ff - 1'b1;
                     end
                  end
                  CMD_FIND: begin
                     op.scan_clr = 1'b1;
                     res_valid   = 1'b0;
                  end
                  CMD_GET: begin
                     if (pos_c >= cnt_x) begin
                        res.status     = ST_BADPOS;
                        res.read_value = err_ff;
                     end else begin
                        op.scan_clr = 1'b1;
                        res_valid   = 1'b0;
                     end
                  end
                  CMD_CLEAR: count_in = '0;
                  default: ;
               endcase
            end
         end
         S_SCAN: op.scan_step = 1'b1;
         S_FINISH: begin
            res_valid = 1'b1;
            if (cmd_ff == CMD_FIND) begin
               if (hit_w[0]) begin
                  res.found_index = scan_idx_x[4:0];
               end else begin
                  res.status = ST_NOTFOUND;
               end
            end else begin
               res.read_value = scan_rd;
            end
         end
         default: ;
      endcase
      res.count    = cnt_after_x[5:0];
      res.is_empty = (count_in == '0);
   end

   // latches for the scan, counter and miss value register
   always_comb begin
      cmd_in      = accept ? cmd_c : cmd_ff;
      key_in      = accept ? key_c : key_ff;
      pos_in      = accept ? pos_c : pos_ff;
      scan_cnt_in = (state_ff == S_SCAN) ? scan_cnt_ff + 1'b1 : '0;
      err_in      = csr_write_enable ? csr_write_data : err_ff;
   end

   // response register with one holding slot behind it
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_in        = rsp_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      if (!rsp_valid_ff || !rsp_stall) begin
         if (pend_valid_ff) begin
            rsp_valid_in  = 1'b1;
            rsp_in        = pend_ff;
            pend_valid_in = res_valid;
            pend_in       = res;
         end else begin
            rsp_valid_in = res_valid;
            rsp_in       = res;
         end
      end else if (res_valid) begin
         pend_valid_in = 1'b1;
         pend_in       = res;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      pos_ff  <= pos_in;
      rsp_ff  <= rsp_in;
      pend_ff <= pend_in;
      if (reset) begin
         state_ff      <= S_IDLE;
         scan_cnt_ff   <= '0;
         count_ff      <= '0;
         err_ff        <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         scan_cnt_ff   <= scan_cnt_in;
         count_ff      <= count_in;
         err_ff        <= err_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   // row of cells; carry enters at the top and drains toward cell zero
   assign hit_w[DEPTH] = 1'b0;
   assign val_w[DEPTH] = '0;
   assign idx_w[DEPTH] = '0;

   generate
      for (genvar i = 0; i < DEPTH; i++) begin : g_cell
         logic [EW-1:0] below_c;
         logic [EW-1:0] above_c;
         if (i == 0) begin : g_bottom
            assign below_c = '0;
         end else begin : g_mid_lo
            assign below_c = entry_w[i-1];
         end
         if (i == DEPTH - 1) begin : g_top
            assign above_c = '0;
         end else begin : g_mid_hi
            assign above_c = entry_w[i+1];
         end
         alt_cell #(
            .EW    (EW),
            .IW    (IW),
            .CW    (CW),
            .INDEX (i)
         ) u_cell (
            .clock   (clock),
            .reset   (reset),
            .op      (op),
            .pos     (cell_pos),
            .count   (cnt_x),
            .key     (cell_key),
            .below   (below_c),
            .above   (above_c),
            .hit_up  (hit_w[i+1]),
            .val_up  (val_w[i+1]),
            .idx_up  (idx_w[i+1]),
            .entry   (entry_w[i]),
            .hit_out (hit_w[i]),
            .val_out (val_w[i]),
            .idx_out (idx_w[i])
         );
      end
   endgenerate

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_ff.status;
   assign rsp_read_value  = rsp_ff.read_value;
   assign rsp_found_index = rsp_ff.found_index;
   assign rsp_count       = rsp_ff.count;
   assign rsp_is_empty    = rsp_ff.is_empty;

endmodule

// ===== sv/alt_cell.sv =====
// ----------------------------------------------------------------------------
// alt_cell
// One list slot: holds an entry, shifts with its neighbors, and forwards the
// scan carry toward slot zero.
// ----------------------------------------------------------------------------
module alt_cell
   import alt_pkg::*;
#(
   parameter int unsigned EW    = ELEMENT_WIDTH_DEF,
   parameter int unsigned IW    = 5,
   parameter int unsigned CW    = 6,
   parameter int unsigned INDEX = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  op_type        op,
   input  logic [CW-1:0] pos,
   input  logic [CW-1:0] count,
   input  logic [EW-1:0] key,
   input  logic [EW-1:0] below,
   input  logic [EW-1:0] above,
   input  logic          hit_up,
   input  logic [EW-1:0] val_up,
   input  logic [IW-1:0] idx_up,
   output logic [EW-1:0] entry,
   output logic          hit_out,
   output logic [EW-1:0] val_out,
   output logic [IW-1:0] idx_out
);

   localparam logic [CW-1:0] IDX_C  = CW'(INDEX);
   localparam logic [CW-1:0] IDX_NX = CW'(INDEX + 1);
   localparam logic [IW-1:0] IDX_ID = IW'(INDEX);

   logic [EW-1:0] entry_ff, entry_in;
   logic          hit_ff, hit_in;
   logic [EW-1:0] val_ff, val_in;
   logic [IW-1:0] idx_ff, idx_in;
   logic          sel;

   assign sel = (IDX_C < count) && (op.find_mode ? (entry_ff == key) : (IDX_C == pos));

   always_comb begin
      entry_in = entry_ff;
      if (op.app && IDX_C == count) begin
         entry_in = key;
      end else if (op.ins) begin
         if (IDX_C == pos) begin
            entry_in = key;
         end else if (IDX_C > pos && IDX_C <= count) begin
            entry_in = below;
         end
      end else if (op.del && IDX_C >= pos && IDX_NX < count) begin
         entry_in = above;
      end
   end

   always_comb begin
      hit_in = hit_ff;
      val_in = val_ff;
      idx_in = idx_ff;
      if (op.scan_clr) begin
         hit_in = 1'b0;
      end else if (op.scan_step) begin
         hit_in = sel | hit_up;
         val_in = sel ? entry_ff : val_up;
         idx_in = sel ? IDX_ID : idx_up;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      val_ff   <= val_in;
      idx_ff   <= idx_in;
      if (reset) begin
         hit_ff <= 1'b0;
      end else begin
         hit_ff <= hit_in;
      end
   end

   assign entry   = entry_ff;
   assign hit_out = hit_ff;
   assign val_out = val_ff;
   assign idx_out = idx_ff;

endmodule
